>>> hdl/mps_pkg.sv
// types, constants and codes shared by the memory pattern self-test block
package mps_pkg;

    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 32;
    localparam int COUNT_W      = 19;
    localparam int PADDR_W      = 3;
    localparam int INDEX_BITS_D = 18;

    localparam logic [ADDR_W-1:0]  RESET_BASE  = 32'h4040_0000;
    localparam logic [COUNT_W-1:0] RESET_COUNT = 19'd262144;
    localparam logic [DATA_W-1:0]  PAT_A       = 32'hAAAA_AAAA;
    localparam logic [DATA_W-1:0]  PAT_B       = 32'h5555_5555;

    // register index, taken from paddr[2]
    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    // odd phases write, even phases read back
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WR_INC = 3'd1,
        PH_RD_INC = 3'd2,
        PH_WR_A   = 3'd3,
        PH_RD_A   = 3'd4,
        PH_WR_B   = 3'd5,
        PH_RD_B   = 3'd6,
        PH_CLEAR  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        FAIL_NONE  = 2'd0,
        FAIL_INC   = 2'd1,
        FAIL_PAT_A = 2'd2,
        FAIL_PAT_B = 2'd3
    } t_fail;

    typedef struct packed {
        logic [ADDR_W-1:0]  base_address;
        logic [COUNT_W-1:0] word_count;
    } t_cfg;

    typedef struct packed {
        logic              start_req;
        logic [DATA_W-1:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] mem_address;
        logic              mem_write;
        logic              mem_read;
        logic [DATA_W-1:0] write_data;
        logic              busy_res;
        logic              done_res;
        logic              passed;
        logic [1:0]        fail_phase;
    } t_out_item;

endpackage

>>> hdl/mps_cfg.sv
// configuration registers behind the apb-style port
module mps_cfg
    import mps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [ADDR_W-1:0]  r_base;
    logic [COUNT_W-1:0] r_count;
    logic               wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RESET_BASE;
            r_count <= RESET_COUNT;
        end else if (wr_en) begin
            case (paddr[2])
                REG_BASE:  r_base  <= pwdata;
                REG_COUNT: r_count <= pwdata[COUNT_W-1:0];
                default:   r_base  <= r_base;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BASE:  prdata = r_base;
            REG_COUNT: prdata = DATA_W'(r_count);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.base_address = r_base;
    assign o_cfg.word_count   = r_count;

endmodule

>>> hdl/mps_engine.sv
// test sequencer: phase and word index state, pattern compare, one access per step
module mps_engine
    import mps_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_D
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam int CW = (INDEX_BITS + 1 > COUNT_W) ? INDEX_BITS + 1 : COUNT_W;

    t_phase                r_phase,    n_phase;
    logic [INDEX_BITS-1:0] r_index,    n_index;
    logic                  r_pending,  n_pending;
    logic [DATA_W-1:0]     r_expected, n_expected;
    t_fail                 r_code,     n_code;
    logic                  r_finished, n_finished;

    logic                  fail_now;
    logic                  start_now;
    logic                  active;
    t_phase                act_phase;
    logic [2:0]            act_bits;
    logic [INDEX_BITS-1:0] act_index;
    logic [CW-1:0]         cnt_ext;
    logic [CW-1:0]         limit;
    logic [CW-1:0]         eff;
    logic [CW-1:0]         idx_inc;
    logic                  last;
    logic [DATA_W-1:0]     pattern;

    // decode: compare returning data, take a start, find end of pass, pick the pattern
    always_comb begin
        fail_now  = r_pending && (i_item.read_data != r_expected);
        start_now = !fail_now && (r_phase == PH_IDLE) && i_item.start_req;
        act_phase = start_now ? PH_WR_INC : r_phase;
        act_bits  = act_phase;
        act_index = start_now ? '0 : r_index;
        active    = !fail_now && (act_phase != PH_IDLE);

        cnt_ext = CW'(i_cfg.word_count);
        limit   = CW'(1) << INDEX_BITS;
        if (cnt_ext == '0) begin
            eff = CW'(1);
        end else if (cnt_ext > limit) begin
            eff = limit;
        end else begin
            eff = cnt_ext;
        end
        idx_inc = CW'(act_index) + CW'(1);
        last    = (idx_inc >= eff);

        case (act_phase)
            PH_WR_INC, PH_RD_INC: pattern = DATA_W'(act_index);
            PH_WR_A, PH_RD_A:     pattern = PAT_A;
            PH_WR_B, PH_RD_B:     pattern = PAT_B;
            default:              pattern = '0;
        endcase
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_index    = r_index;
        n_pending  = r_pending;
        n_expected = r_expected;
        n_code     = r_code;
        n_finished = r_finished;
        if (i_step) begin
            n_pending = 1'b0;
            if (fail_now) begin
                n_code     = t_fail'(r_phase[2:1]);
                n_finished = 1'b1;
                n_phase    = PH_IDLE;
                n_index    = '0;
            end else begin
                if (start_now) begin
                    n_phase    = PH_WR_INC;
                    n_finished = 1'b0;
                    n_code     = FAIL_NONE;
                end
                if (active) begin
                    if (!act_bits[0]) begin
                        n_pending  = 1'b1;
                        n_expected = pattern;
                    end
                    if (last) begin
                        n_index = '0;
                        if (act_phase == PH_CLEAR) begin
                            n_phase    = PH_IDLE;
                            n_finished = 1'b1;
                            n_code     = FAIL_NONE;
                        end else begin
                            n_phase = t_phase'(act_bits + 3'd1);
                        end
                    end else begin
                        n_index = idx_inc[INDEX_BITS-1:0];
                    end
                end
            end
        end
    end

    // result of this step
    always_comb begin
        o_result             = '0;
        if (active) begin
            o_result.mem_address = i_cfg.base_address + (ADDR_W'(act_index) << 2);
            o_result.mem_write   = act_bits[0];
            o_result.mem_read    = !act_bits[0];
            o_result.write_data  = act_bits[0] ? pattern : '0;
        end
        o_result.busy_res   = (n_phase != PH_IDLE) || n_pending;
        o_result.done_res   = n_finished;
        o_result.passed     = n_finished && (n_code == FAIL_NONE);
        o_result.fail_phase = n_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_index    <= '0;
            r_pending  <= 1'b0;
            r_expected <= '0;
            r_code     <= FAIL_NONE;
            r_finished <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_index    <= n_index;
            r_pending  <= n_pending;
            r_expected <= n_expected;
            r_code     <= n_code;
            r_finished <= n_finished;
        end
    end

endmodule

>>> hdl/memory_pattern_self_test.sv
// top level of the memory pattern self-test engine
// Memory pattern self-test engine. Each input transfer is one clock tick of the test:
// it carries a start request and the read data for the read issued on the tick
// before, and it yields exactly one result transfer describing this tick's memory
// access (address, read/write strobes, write data) and the test status. A start
// runs seven passes over word_count words at base_address: write index, verify,
// write 0xAAAAAAAA, verify, write 0x55555555, verify, clear to zero. The first
// mismatch ends the run without the clear pass and reports the failing pattern in
// fail_phase (1 incremental, 2 pattern A, 3 pattern B). The block takes one transfer
// per clock and gives one result per clock while the result side does not stall; each
// tick goes through the input register, the sequencer logic and the result register.
// A stall on the result side holds the pipe, and the input stall rises only while
// both stages are full. Registers: base_address at byte 0, word_count at byte 4;
// a word count of zero acts as one and counts above 2^INDEX_BITS are clamped.
// Registers are meant to be written while no test transfer is in flight.
module memory_pattern_self_test
    import mps_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_D
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_cfg      cfg;
    t_out_item step_result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free;   // result register can take a new value this cycle
    logic      step;       // the held tick is processed and its result captured
    logic      in_load;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign in_load    = !r_in_valid || out_free;
    assign o_in_stall = !in_load;

    mps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer state advances only on a processed tick
    mps_engine #(
        .INDEX_BITS (INDEX_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a tick never reads and writes at once
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.mem_write && o_out_item.mem_read))
        else $error("read and write strobes both set");

    // a pass is only reported on a finished run with no failure code
    a_pass_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.passed) |->
            (o_out_item.done_res && (o_out_item.fail_phase == FAIL_NONE)))
        else $error("pass reported without done or with a fail code");

    // busy and done exclude each other
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.busy_res && o_out_item.done_res))
        else $error("busy and done both set");

    // input stalls only when the result side is backed up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled with result side free");

endmodule
